FILE: sv/mlps_pkg.sv
// Shared types, codes and fixed-point constants for the motor link supervisor.
package mlps_pkg;

    // Configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_ALIVE = 1'b0;
    localparam logic CFG_IDX_POLL  = 1'b1;
    localparam logic [15:0] ALIVE_PERIOD_RST = 16'd200;
    localparam logic [15:0] POLL_PERIOD_RST  = 16'd50;

    // Answer and request action codes
    localparam logic [7:0] ACT_NONE      = 8'd0;
    localparam logic [7:0] ACT_CURRENTS  = 8'd1;
    localparam logic [7:0] ACT_FAULTS    = 8'd2;
    localparam logic [7:0] ACT_ARM       = 8'd11;
    localparam logic [7:0] ACT_DISARM    = 8'd12;
    localparam logic [7:0] ACT_DISARM_B  = 8'd13;
    localparam logic [7:0] ACT_TEMP      = 8'd15;
    localparam logic [7:0] ACT_VOLT      = 8'd16;
    localparam logic [7:0] ACT_FAULT_ONE = 8'd18;
    localparam logic [7:0] ACT_FAULT_TWO = 8'd19;
    localparam logic [7:0] ACT_ALIVE     = 8'd111;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_ALIVE   = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_CONNECT = 2'd3
    } t_req;

    typedef enum logic {
        LINK_DOWN = 1'b0,
        LINK_UP   = 1'b1
    } t_link;

    // Voltage: mV = v * 1e9 / 72013093, done as |v| * ceil(2^42 * 1e9 / D) >> 42.
    // The reciprocal is built by long division so nothing overflows 64 bits.
    localparam longint unsigned VOLT_NUM   = 64'd1000000000;
    localparam longint unsigned VOLT_DIV   = 64'd72013093;
    localparam int              VOLT_SHIFT = 42;
    localparam longint unsigned VOLT_INT   = VOLT_NUM / VOLT_DIV;
    localparam longint unsigned VOLT_REM   = VOLT_NUM % VOLT_DIV;
    localparam longint unsigned VOLT_Q1    = (VOLT_REM << 20) / VOLT_DIV;
    localparam longint unsigned VOLT_R1    = (VOLT_REM << 20) % VOLT_DIV;
    localparam longint unsigned VOLT_Q2    = ((VOLT_R1 << 22) + VOLT_DIV - 64'd1) / VOLT_DIV;
    localparam longint unsigned VOLT_RECIP =
        (VOLT_INT << VOLT_SHIFT) + (VOLT_Q1 << 22) + VOLT_Q2;
    localparam int VOLT_MAG_W   = 14;
    localparam int VOLT_RECIP_W = 46;
    localparam int VOLT_PROD_W  = VOLT_MAG_W + VOLT_RECIP_W;
    localparam int VOLT_Q_W     = 18;

    // Temperature: tenths = (100000*v - 8184000) / 39897, via |w| * ceil(2^46 / D) >> 46.
    localparam longint unsigned TEMP_DIV   = 64'd39897;
    localparam int              TEMP_SHIFT = 46;
    localparam longint unsigned TEMP_RECIP = ((64'd1 << TEMP_SHIFT) + TEMP_DIV - 64'd1) / TEMP_DIV;
    localparam int TEMP_MAG_W   = 31;
    localparam int TEMP_RECIP_W = 31;
    localparam int TEMP_PROD_W  = TEMP_MAG_W + TEMP_RECIP_W;
    localparam int TEMP_Q_W     = 16;

    typedef struct packed {
        logic [31:0] time_now;
        logic        send_ok;
        logic        answer_valid;
        logic [7:0]  answer_action;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
        logic [7:0]  byte_four;
        logic        close_event;
        logic        connect_ok;
    } t_item;

    // Request fields plus store write enables for one call
    typedef struct packed {
        t_req        req;
        logic [7:0]  act;
        logic        sock;
        logic        armed;
        logic        link;
        logic [31:0] now;
        logic        ans_we;
        logic        cur_we;
        logic [15:0] cur0;
        logic [15:0] cur1;
        logic        flt0_we;
        logic        flt0;
        logic        flt1_we;
        logic        flt1;
        logic        volt_we;
        logic        volt_neg;
        logic        temp_we;
        logic        temp_neg;
    } t_upd;

    typedef struct packed {
        logic [VOLT_MAG_W-1:0] abs_v;
        logic [TEMP_MAG_W-1:0] abs_w;
    } t_mag;

    function automatic logic [7:0] query_code(input logic [2:0] step);
        logic [7:0] code;
        case (step)
            3'd1:    code = ACT_VOLT;
            3'd2:    code = ACT_FAULT_ONE;
            3'd3:    code = ACT_FAULT_TWO;
            3'd4:    code = ACT_CURRENTS;
            3'd5:    code = ACT_TEMP;
            default: code = ACT_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/motor_link_poll_and_status_core.sv
// Top level of the motor link supervisor: transfer pipeline and status stores.
//
// One input transfer is one service call (time stamp, send and connect outcomes,
// optional answer packet, close event). Every call yields exactly one result:
// the request to issue (none, keepalive, query, connect) with its action code,
// the socket reset flag, and the link, armed and status values after the call.
// The alive and poll periods sit behind the APB port; write them while idle.
// The datapath is a four-register pipeline: input register, sequencer/decode
// stage, reciprocal multiply stage, result register. One call can be taken
// every cycle while o_stall is low. Each stage advances whenever the stage
// after it is empty or moving, so bubbles close up and o_stall only rises
// when every stage is full and i_stall holds the result register. A held
// result keeps all its fields. Reset empties the pipeline, drops the link,
// clears armed and the keepalive error, zeroes the poll step, time stamps
// and status stores, and restores the default periods of 200 ms (keepalive)
// and 50 ms (poll).
module motor_link_poll_and_status_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // service call input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_time_now,
    input  logic                            i_send_ok,
    input  logic                            i_answer_valid,
    input  logic [7:0]                      i_answer_action,
    input  logic signed [7:0]               i_byte_one,
    input  logic signed [7:0]               i_byte_two,
    input  logic signed [7:0]               i_byte_three,
    input  logic signed [7:0]               i_byte_four,
    input  logic                            i_close_event,
    input  logic                            i_connect_ok,
    // result output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_request,
    output logic [7:0]                      o_request_action,
    output logic                            o_socket_reset,
    output logic                            o_armed_flag,
    output logic                            o_link_up,
    output logic [15:0]                     o_motor_one_current,
    output logic [15:0]                     o_motor_two_current,
    output logic                            o_motor_one_fault,
    output logic                            o_motor_two_fault,
    output logic signed [18:0]              o_battery_millivolts,
    output logic signed [16:0]              o_temperature_tenths,
    output logic [31:0]                     o_last_answer_time
);

    logic [15:0] alive_period, poll_period;

    mlps_pkg::t_item in_item;
    mlps_pkg::t_item r_s1;
    mlps_pkg::t_upd  s2_upd, r_s2_upd, r_s3_upd;
    mlps_pkg::t_mag  s2_mag, r_s2_mag;
    logic r_v1, r_v2, r_v3, r_vo;
    logic out_free, free3, free2, free1;
    logic adv1, adv2, adv3, accept;

    logic [mlps_pkg::VOLT_Q_W-1:0] volt_mag;
    logic [mlps_pkg::TEMP_Q_W-1:0] temp_mag;
    logic signed [18:0] volt_val;
    logic signed [16:0] temp_val;

    mlps_pkg::t_req r_req;
    logic [7:0]  r_act;
    logic        r_sock, r_armed, r_link;
    logic [15:0] r_cur0, r_cur1;
    logic        r_flt0, r_flt1;
    logic signed [18:0] r_volt;
    logic signed [16:0] r_temp;
    logic [31:0] r_ans_time;

    mlps_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_alive_period (alive_period),
        .o_poll_period  (poll_period)
    );

    // Stage handshake: each stage moves when the next is empty or moving
    assign out_free = !r_vo || !i_stall;
    assign adv3     = r_v3 && out_free;
    assign free3    = !r_v3 || out_free;
    assign adv2     = r_v2 && free3;
    assign free2    = !r_v2 || free3;
    assign adv1     = r_v1 && free2;
    assign free1    = !r_v1 || free2;
    assign o_stall  = !free1;
    assign accept   = i_valid && free1;

    always_comb begin
        in_item.time_now      = i_time_now;
        in_item.send_ok       = i_send_ok;
        in_item.answer_valid  = i_answer_valid;
        in_item.answer_action = i_answer_action;
        in_item.byte_one      = i_byte_one;
        in_item.byte_two      = i_byte_two;
        in_item.byte_three    = i_byte_three;
        in_item.byte_four     = i_byte_four;
        in_item.close_event   = i_close_event;
        in_item.connect_ok    = i_connect_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= (r_v1 && !adv1) || accept;
            r_v2 <= (r_v2 && !adv2) || adv1;
            r_v3 <= (r_v3 && !adv3) || adv2;
            r_vo <= (r_vo && i_stall) || adv3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= in_item;
        end
        if (adv1) begin
            r_s2_upd <= s2_upd;
            r_s2_mag <= s2_mag;
        end
        if (adv2) begin
            r_s3_upd <= r_s2_upd;
        end
    end

    mlps_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv1),
        .i_item         (r_s1),
        .i_alive_period (alive_period),
        .i_poll_period  (poll_period),
        .o_upd          (s2_upd),
        .o_mag          (s2_mag)
    );

    mlps_conv u_conv (
        .i_clk      (i_clk),
        .i_en       (adv2),
        .i_mag      (r_s2_mag),
        .o_volt_mag (volt_mag),
        .o_temp_mag (temp_mag)
    );

    // Quotients were taken on magnitudes, so the sign goes back on here
    always_comb begin
        volt_val = r_s3_upd.volt_neg ? -$signed({1'b0, volt_mag}) : $signed({1'b0, volt_mag});
        temp_val = r_s3_upd.temp_neg ? -$signed({1'b0, temp_mag}) : $signed({1'b0, temp_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req      <= mlps_pkg::REQ_NONE;
            r_act      <= mlps_pkg::ACT_NONE;
            r_sock     <= 1'b0;
            r_armed    <= 1'b0;
            r_link     <= 1'b0;
            r_cur0     <= 16'd0;
            r_cur1     <= 16'd0;
            r_flt0     <= 1'b0;
            r_flt1     <= 1'b0;
            r_volt     <= 19'sd0;
            r_temp     <= 17'sd0;
            r_ans_time <= 32'd0;
        end else if (adv3) begin
            r_req   <= r_s3_upd.req;
            r_act   <= r_s3_upd.act;
            r_sock  <= r_s3_upd.sock;
            r_armed <= r_s3_upd.armed;
            r_link  <= r_s3_upd.link;
            if (r_s3_upd.ans_we) begin
                r_ans_time <= r_s3_upd.now;
            end
            if (r_s3_upd.cur_we) begin
                r_cur0 <= r_s3_upd.cur0;
                r_cur1 <= r_s3_upd.cur1;
            end
            if (r_s3_upd.flt0_we) begin
                r_flt0 <= r_s3_upd.flt0;
            end
            if (r_s3_upd.flt1_we) begin
                r_flt1 <= r_s3_upd.flt1;
            end
            if (r_s3_upd.volt_we) begin
                r_volt <= volt_val;
            end
            if (r_s3_upd.temp_we) begin
                r_temp <= temp_val;
            end
        end
    end

    assign o_valid              = r_vo;
    assign o_request            = r_req;
    assign o_request_action     = r_act;
    assign o_socket_reset       = r_sock;
    assign o_armed_flag         = r_armed;
    assign o_link_up            = r_link;
    assign o_motor_one_current  = r_cur0;
    assign o_motor_two_current  = r_cur1;
    assign o_motor_one_fault    = r_flt0;
    assign o_motor_two_fault    = r_flt1;
    assign o_battery_millivolts = r_volt;
    assign o_temperature_tenths = r_temp;
    assign o_last_answer_time   = r_ans_time;

endmodule

FILE: sv/mlps_cfg.sv
// APB register file for the keepalive and poll periods.
module mlps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mlps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [15:0]                    o_alive_period,
    output logic [15:0]                    o_poll_period
);

    logic [15:0] r_alive_period;
    logic [15:0] r_poll_period;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive_period <= mlps_pkg::ALIVE_PERIOD_RST;
            r_poll_period  <= mlps_pkg::POLL_PERIOD_RST;
        end else if (wr_en) begin
            case (paddr[2])
                mlps_pkg::CFG_IDX_ALIVE: r_alive_period <= pwdata[15:0];
                mlps_pkg::CFG_IDX_POLL:  r_poll_period  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mlps_pkg::CFG_IDX_ALIVE: prdata = {16'd0, r_alive_period};
            mlps_pkg::CFG_IDX_POLL:  prdata = {16'd0, r_poll_period};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_alive_period = r_alive_period;
    assign o_poll_period  = r_poll_period;

endmodule

FILE: sv/mlps_ctrl.sv
// Link, keepalive and poll sequencer with answer decode for one service call.
module mlps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mlps_pkg::t_item i_item,
    input  logic [15:0]     i_alive_period,
    input  logic [15:0]     i_poll_period,
    output mlps_pkg::t_upd  o_upd,
    output mlps_pkg::t_mag  o_mag
);

    mlps_pkg::t_link r_link, n_link;
    logic        r_armed, n_armed;
    logic        r_ka_err, n_ka_err;
    logic [31:0] r_last_ka, n_last_ka;
    logic [31:0] r_last_poll, n_last_poll;
    logic [2:0]  r_step, n_step;

    logic [31:0] ka_age, poll_age;
    logic        ka_due, poll_due, poll_go;
    logic [2:0]  step_inc;

    logic signed [14:0] b1_15, b2_15, v;
    logic signed [15:0] b1_16, b2_16, b3_16, b4_16;
    logic signed [31:0] b1_32, b2_32, w;
    logic [14:0] v_mag;
    logic [31:0] w_mag;
    logic        ans;

    assign ka_age   = i_item.time_now - r_last_ka;
    assign poll_age = i_item.time_now - r_last_poll;
    assign ka_due   = ka_age > {16'd0, i_alive_period};
    assign poll_due = poll_age > {16'd0, i_poll_period};
    assign poll_go  = !ka_due && !r_ka_err && poll_due;
    assign step_inc = r_step + 3'd1;

    assign b1_15 = {{7{i_item.byte_one[7]}}, i_item.byte_one};
    assign b2_15 = {{7{i_item.byte_two[7]}}, i_item.byte_two};
    assign b1_16 = {{8{i_item.byte_one[7]}}, i_item.byte_one};
    assign b2_16 = {{8{i_item.byte_two[7]}}, i_item.byte_two};
    assign b3_16 = {{8{i_item.byte_three[7]}}, i_item.byte_three};
    assign b4_16 = {{8{i_item.byte_four[7]}}, i_item.byte_four};
    assign b1_32 = {{24{i_item.byte_one[7]}}, i_item.byte_one};
    assign b2_32 = {{24{i_item.byte_two[7]}}, i_item.byte_two};

    // v = b1*100 + b2 fits 15 bits; w = 20*(5000*v - 409200) fits 32 bits
    assign v     = b1_15 * 15'sd100 + b2_15;
    assign w     = b1_32 * 32'sd10000000 + b2_32 * 32'sd100000 - 32'sd8184000;
    assign v_mag = v[14] ? 15'(-v) : 15'(v);
    assign w_mag = w[31] ? 32'(-w) : 32'(w);
    assign ans   = (r_link == mlps_pkg::LINK_UP) && i_item.answer_valid;

    // Next state
    always_comb begin
        n_link      = r_link;
        n_armed     = r_armed;
        n_ka_err    = r_ka_err;
        n_last_ka   = r_last_ka;
        n_last_poll = r_last_poll;
        n_step      = r_step;
        case (r_link)
            mlps_pkg::LINK_UP: begin
                if (r_armed) begin
                    if (ka_due) begin
                        n_last_ka = i_item.time_now;
                        n_ka_err  = !i_item.send_ok;
                    end else if (poll_go) begin
                        n_last_poll = i_item.time_now;
                        // after the last query the step wraps back to idle
                        if (step_inc inside {[3'd1:3'd4]}) begin
                            n_step = step_inc;
                        end else begin
                            n_step = 3'd0;
                        end
                    end
                end
                if (ans) begin
                    case (i_item.answer_action)
                        mlps_pkg::ACT_ARM:      n_armed = 1'b1;
                        mlps_pkg::ACT_DISARM:   n_armed = 1'b0;
                        mlps_pkg::ACT_DISARM_B: n_armed = 1'b0;
                        default: ;
                    endcase
                end
                if (i_item.close_event) begin
                    n_link = mlps_pkg::LINK_DOWN;
                end
            end
            mlps_pkg::LINK_DOWN: begin
                n_link = i_item.connect_ok ? mlps_pkg::LINK_UP : mlps_pkg::LINK_DOWN;
            end
            default: n_link = mlps_pkg::LINK_DOWN;
        endcase
    end

    // Outputs
    always_comb begin
        o_upd          = '0;
        o_upd.req      = mlps_pkg::REQ_NONE;
        o_upd.act      = mlps_pkg::ACT_NONE;
        o_upd.armed    = n_armed;
        o_upd.link     = (n_link == mlps_pkg::LINK_UP);
        o_upd.now      = i_item.time_now;
        o_upd.ans_we   = ans;
        o_upd.cur0     = 16'(b1_16 * 16'sd1000 + (b2_16 <<< 3));
        o_upd.cur1     = 16'(b3_16 * 16'sd1000 + (b4_16 <<< 3));
        o_upd.volt_neg = v[14];
        o_upd.temp_neg = w[31];
        case (r_link)
            mlps_pkg::LINK_UP: begin
                if (r_armed) begin
                    if (ka_due) begin
                        o_upd.req = mlps_pkg::REQ_ALIVE;
                        o_upd.act = mlps_pkg::ACT_ALIVE;
                    end else if (poll_go && (step_inc inside {[3'd1:3'd5]})) begin
                        o_upd.req = mlps_pkg::REQ_QUERY;
                        o_upd.act = mlps_pkg::query_code(step_inc);
                    end
                end
                o_upd.sock = i_item.close_event;
            end
            mlps_pkg::LINK_DOWN: o_upd.req = mlps_pkg::REQ_CONNECT;
            default:             o_upd.req = mlps_pkg::REQ_NONE;
        endcase
        case (i_item.answer_action)
            mlps_pkg::ACT_CURRENTS: o_upd.cur_we = ans;
            mlps_pkg::ACT_FAULTS: begin
                o_upd.flt0_we = ans;
                o_upd.flt0    = (i_item.byte_one != 8'd0);
                o_upd.flt1_we = ans;
                o_upd.flt1    = (i_item.byte_two != 8'd0);
            end
            mlps_pkg::ACT_FAULT_ONE: begin
                o_upd.flt0_we = ans;
                o_upd.flt0    = (v != 15'sd0);
            end
            mlps_pkg::ACT_FAULT_TWO: begin
                o_upd.flt1_we = ans;
                o_upd.flt1    = (v != 15'sd0);
            end
            mlps_pkg::ACT_VOLT: o_upd.volt_we = ans;
            mlps_pkg::ACT_TEMP: o_upd.temp_we = ans;
            default: ;
        endcase
    end

    assign o_mag.abs_v = v_mag[mlps_pkg::VOLT_MAG_W-1:0];
    assign o_mag.abs_w = w_mag[mlps_pkg::TEMP_MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= mlps_pkg::LINK_DOWN;
            r_armed     <= 1'b0;
            r_ka_err    <= 1'b0;
            r_last_ka   <= 32'd0;
            r_last_poll <= 32'd0;
            r_step      <= 3'd0;
        end else if (i_en) begin
            r_link      <= n_link;
            r_armed     <= n_armed;
            r_ka_err    <= n_ka_err;
            r_last_ka   <= n_last_ka;
            r_last_poll <= n_last_poll;
            r_step      <= n_step;
        end
    end

endmodule

FILE: sv/mlps_conv.sv
// Reciprocal multiply stage for the voltage and temperature conversions.
module mlps_conv (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  mlps_pkg::t_mag                   i_mag,
    output logic [mlps_pkg::VOLT_Q_W-1:0]    o_volt_mag,
    output logic [mlps_pkg::TEMP_Q_W-1:0]    o_temp_mag
);

    logic [mlps_pkg::VOLT_PROD_W-1:0] r_volt_prod, n_volt_prod;
    logic [mlps_pkg::TEMP_PROD_W-1:0] r_temp_prod, n_temp_prod;

    assign n_volt_prod = mlps_pkg::VOLT_PROD_W'(i_mag.abs_v)
                       * mlps_pkg::VOLT_PROD_W'(mlps_pkg::VOLT_RECIP);
    assign n_temp_prod = mlps_pkg::TEMP_PROD_W'(i_mag.abs_w)
                       * mlps_pkg::TEMP_PROD_W'(mlps_pkg::TEMP_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_volt_prod <= n_volt_prod;
            r_temp_prod <= n_temp_prod;
        end
    end

    // Truncating quotients of the magnitudes
    assign o_volt_mag = r_volt_prod[mlps_pkg::VOLT_SHIFT +: mlps_pkg::VOLT_Q_W];
    assign o_temp_mag = r_temp_prod[mlps_pkg::TEMP_SHIFT +: mlps_pkg::TEMP_Q_W];

endmodule

FILE: sv/mlps_checker.sv
// Port-level checks for the motor link supervisor, bound to its top level.
module mlps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_request,
    input logic [7:0]  o_request_action,
    input logic        o_socket_reset,
    input logic        o_link_up,
    input logic [31:0] o_last_answer_time
);

    // A held result keeps its request and answer time
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_request)
            && $stable(o_request_action) && $stable(o_last_answer_time))
        else $error("result changed while stalled");

    a_alive_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_request == mlps_pkg::REQ_ALIVE)
            |-> o_request_action == mlps_pkg::ACT_ALIVE)
        else $error("keepalive with wrong action");

    a_query_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_request == mlps_pkg::REQ_QUERY)
            |-> (o_request_action == mlps_pkg::ACT_VOLT)
             || (o_request_action == mlps_pkg::ACT_FAULT_ONE)
             || (o_request_action == mlps_pkg::ACT_FAULT_TWO)
             || (o_request_action == mlps_pkg::ACT_CURRENTS)
             || (o_request_action == mlps_pkg::ACT_TEMP))
        else $error("query with unknown action");

    // A close is only seen on an up link, and it drops the link
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_socket_reset
            |-> !o_link_up && (o_request != mlps_pkg::REQ_CONNECT))
        else $error("socket reset with link still up or on connect");

    a_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_request == mlps_pkg::REQ_CONNECT)
            |-> (o_request_action == mlps_pkg::ACT_NONE) && !o_socket_reset)
        else $error("connect request carries action or socket reset");

endmodule

bind motor_link_poll_and_status_core mlps_checker u_mlps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_request          (o_request),
    .o_request_action   (o_request_action),
    .o_socket_reset     (o_socket_reset),
    .o_link_up          (o_link_up),
    .o_last_answer_time (o_last_answer_time)
);
